### hdl/obtb_pkg.sv
package obtb_pkg;

  localparam int unsigned OBTB_DEPTH = 4096;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned CAP_W    = 13;
  localparam int unsigned FILL_W   = 13;
  localparam int unsigned DROP_W   = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONSUME = 2'd2;

endpackage

### hdl/overwriting_byte_tail_buffer.sv
// channel  direction  handshake               payload
// in       request    in_valid_i / in_stall_o   func_i, data_byte_i, amount_i
// out      result     out_valid_o / out_stall_i ok_o, read_byte_o, fill_count_o,
//                                               dropped_total_o
// cfg      write      cfg_we_i                  cfg_wdata_i
//
// One request per cycle unless stalled; results pass the pending and output stages.
// Pointers and counters update at acceptance; the byte ring is one memory with one
// write port and one registered read port, read in the acceptance cycle.
// Reset empties the ring and clears the drop counter; capacity returns to 4096.
// A stalled result holds one request in the pending stage; only then is input stalled.
module overwriting_byte_tail_buffer
  import obtb_pkg::*;
#(
  parameter int unsigned DEPTH = OBTB_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CAP_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic [AMOUNT_W-1:0] amount_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                ok_o,
  output logic [BYTE_W-1:0]   read_byte_o,
  output logic [FILL_W-1:0]   fill_count_o,
  output logic [DROP_W-1:0]   dropped_total_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned HW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (HW > AMOUNT_W) ? HW : AMOUNT_W;

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [BYTE_W-1:0] byte_store_q [DEPTH];
  logic [BYTE_W-1:0] rd_q;

  logic [CAP_W-1:0]  cap_q;
  logic [AW-1:0]     oldest_q, oldest_d;
  logic [HW-1:0]     held_q, held_d;
  logic [DROP_W-1:0] drop_q, drop_d;

  logic              pend_valid_q, pend_valid_d;
  logic              pend_ok_q, pend_ok_d;
  logic              pend_peek_q, pend_peek_d;

  logic              out_valid_q, out_valid_d;
  logic              ok_q;
  logic [BYTE_W-1:0] read_byte_q;
  logic [FILL_W-1:0] fill_q;
  logic [DROP_W-1:0] drop_out_q;

  logic              out_free, move, in_acc;
  logic [CW-1:0]     cap_ext, cap_eff, held_ext, amount_ext;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DROP_W-1:0] drop_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign move       = pend_valid_q && out_free;
  assign in_stall_o = pend_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cap_ext    = CW'(cap_q);
  assign cap_eff    = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
  assign held_ext   = CW'(held_q);
  assign amount_ext = CW'(amount_i);
  assign drop_inc   = (drop_q == '1) ? drop_q : drop_q + DROP_W'(1);

  assign wr_addr = ring_pos(oldest_q, held_ext);
  assign rd_addr = ring_pos(oldest_q, amount_ext);

  always_comb begin
    oldest_d  = oldest_q;
    held_d    = held_q;
    drop_d    = drop_q;
    wr_en     = 1'b0;
    pend_ok_d = 1'b0;
    pend_peek_d = 1'b0;
    unique case (func_i)
      FUNC_APPEND: begin
        pend_ok_d = 1'b1;
        if (cap_eff == '0) begin
          drop_d = drop_inc;
        end else begin
          wr_en = 1'b1;
          if (held_ext >= cap_eff) begin
            oldest_d = ring_pos(oldest_q, CW'(1));
            drop_d   = drop_inc;
          end else begin
            held_d = held_q + HW'(1);
          end
        end
      end
      FUNC_PEEK: begin
        pend_peek_d = 1'b1;
        pend_ok_d   = (amount_ext < held_ext);
      end
      FUNC_CONSUME: begin
        if (amount_ext <= held_ext) begin
          pend_ok_d = 1'b1;
          held_d    = HW'(held_ext - amount_ext);
          oldest_d  = (held_ext == amount_ext) ? '0 : rd_addr;
        end
      end
      default: begin
        pend_ok_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (in_acc) begin
      pend_valid_d = 1'b1;
    end else if (move) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && wr_en) begin
      byte_store_q[wr_addr] <= data_byte_i;
    end
    if (in_acc) begin
      rd_q <= byte_store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      oldest_q     <= '0;
      held_q       <= '0;
      drop_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_ok_q    <= 1'b0;
      pend_peek_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        oldest_q    <= oldest_d;
        held_q      <= held_d;
        drop_q      <= drop_d;
        pend_ok_q   <= pend_ok_d;
        pend_peek_q <= pend_peek_d;
      end
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      ok_q        <= pend_ok_q;
      read_byte_q <= (pend_ok_q && pend_peek_q) ? rd_q : '0;
      fill_q      <= FILL_W'(held_ext);
      drop_out_q  <= drop_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign read_byte_o     = read_byte_q;
  assign fill_count_o    = fill_q;
  assign dropped_total_o = drop_out_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_ext <= CW'(DEPTH))
    else $error("fill above ring depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == '0 |-> oldest_q == '0)
    else $error("empty ring with non-zero oldest pointer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> read_byte_o == '0)
    else $error("refused request returned a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 drop_q >= $past(drop_q))
    else $error("drop counter went down");
`endif

endmodule
